// ----- hdl/tun_pkg.sv -----
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants
// Widths of the normalization datapath and the per-cell work record.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int NORM_FRAC = 30;
  localparam int VW        = NORM_FRAC + 1;
  localparam int SW        = 64;
  localparam int TW        = 2 * VW + 2 * NORM_FRAC;
  localparam int PW        = 128;
  localparam int QW        = 96;
  localparam int OUT_W     = 32;

  typedef struct packed {
    logic [SW-1:0]          s;
    logic [2:0][TW-1:0]     t;
    logic [2:0][PW-1:0]     p;
    logic [2:0][QW-1:0]     q;
    logic [2:0][VW-1:0]     m;
    logic [2:0]             neg;
    logic                   degen;
  } tun_work_t;

endpackage

// ----- hdl/triangle_unit_normal.sv -----
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal of a triangle
// Cross product of the edges, scaled to unit length in signed Q2.30.
// ----------------------------------------------------------------------------
// in_tdata carries the nine corner coordinates; one transfer per triangle.
// out_tdata carries the normal, out_tuser the degenerate flag.
// Pipeline: 7 front stages, 31 bit cells and 1 output register from input
// transfer to out_tvalid. Throughput: one triangle per cycle unless stalled;
// the whole pipe advances together.
// Each cell resolves one bit of the normal magnitude with shifts and adds.
// When out_tvalid is high and out_tready low, the pipe holds and in_tready
// drops; nothing is lost. Reset clears all valid bits; the pipe is empty
// after reset.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // normal_x, normal_y, normal_z
  output logic [3*OUT_W-1:0]    out_tdata,
  // degenerate
  output logic                  out_tuser
);

  localparam int CW = COORD_WIDTH;

  logic                        adv;
  logic [8:0][CW-1:0]          corner;
  logic                        f_vld;
  tun_work_t                   f_work;
  logic      [VW:0]            c_vld;
  tun_work_t [VW:0]            c_work;
  logic                        out_vld_r;
  logic [3*OUT_W-1:0]          out_data_r;
  logic                        out_degen_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign corner    = in_tdata[9*CW-1:0];

  tun_front #(.COORD_WIDTH(CW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_tvalid),
    .corner  (corner),
    .out_vld (f_vld),
    .work    (f_work)
  );

  assign c_vld[0]  = f_vld;
  assign c_work[0] = f_work;

  for (genvar g = 0; g < VW; g++) begin : g_cell
    tun_cell #(.BIT(VW - 1 - g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (c_vld[g]),
      .in_work  (c_work[g]),
      .out_vld  (c_vld[g+1]),
      .out_work (c_work[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= c_vld[VW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_degen_r <= c_work[VW].degen;
      for (int i = 0; i < 3; i++) begin
        logic [OUT_W-1:0] mag;
        mag = OUT_W'(c_work[VW].m[i]);
        if (c_work[VW].degen) begin
          out_data_r[i*OUT_W +: OUT_W] <= '0;
        end else if (c_work[VW].neg[i]) begin
          out_data_r[i*OUT_W +: OUT_W] <= -mag;
        end else begin
          out_data_r[i*OUT_W +: OUT_W] <= mag;
        end
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("degenerate result with nonzero normal");

  a_range_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[OUT_W-1:0]) <= $signed(OUT_W'(1 << NORM_FRAC)) &&
                    $signed(out_tdata[OUT_W-1:0]) >= -$signed(OUT_W'(1 << NORM_FRAC))))
    else $error("normal_x out of unit range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

endmodule

// ----- hdl/tun_front.sv -----
// ----------------------------------------------------------------------------
// tun_front: edges, cross product and prescale
// Seven-stage pipeline producing the squared magnitudes and their sum.
// ----------------------------------------------------------------------------
module tun_front import tun_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [8:0][COORD_WIDTH-1:0]  corner,
  output logic                         out_vld,
  output tun_work_t                    work
);

  localparam int CW = COORD_WIDTH;
  localparam int MW = 2 * CW + 1;
  localparam int LW = $clog2(MW + 1);
  localparam int NS = 7;

  logic [NS-1:0] vld_r;

  logic signed [CW-1:0]        ab_r [3];
  logic signed [CW-1:0]        bc_r [3];
  logic signed [2*CW-1:0]      pr_r [6];
  logic [2:0][MW-1:0]          mag_r, mag2_r;
  logic [2:0]                  neg_r, neg2_r, neg3_r, neg4_r;
  logic [LW-1:0]               k_r;
  logic [2:0][VW-1:0]          v_r;
  logic [2:0][2*VW-1:0]        sq_r;
  tun_work_t                   work_r;

  function automatic logic [CW-1:0] sat_diff(logic [CW-1:0] p, logic [CW-1:0] q);
    logic [CW:0] d;
    d = {p[CW-1], p} - {q[CW-1], q};
    if (d[CW] != d[CW-1]) begin
      return {d[CW], {(CW-1){~d[CW]}}};
    end
    return d[CW-1:0];
  endfunction

  logic [MW-1:0] any_mag;
  logic [LW-1:0] len;
  logic [LW-1:0] k_nxt;

  always_comb begin
    any_mag = mag_r[0] | mag_r[1] | mag_r[2];
    len = '0;
    for (int j = 0; j < MW; j++) begin
      if (any_mag[j]) len = LW'(j + 1);
    end
    k_nxt = (len > LW'(VW)) ? len - LW'(VW) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab_r[i] <= sat_diff(corner[3+i], corner[i]);
        bc_r[i] <= sat_diff(corner[6+i], corner[3+i]);
      end
      pr_r[0] <= ab_r[1] * bc_r[2];
      pr_r[1] <= ab_r[2] * bc_r[1];
      pr_r[2] <= ab_r[2] * bc_r[0];
      pr_r[3] <= ab_r[0] * bc_r[2];
      pr_r[4] <= ab_r[0] * bc_r[1];
      pr_r[5] <= ab_r[1] * bc_r[0];
      for (int i = 0; i < 3; i++) begin
        logic signed [MW-1:0] cr;
        cr = MW'(pr_r[2*i]) - MW'(pr_r[2*i+1]);
        neg_r[i] <= cr[MW-1];
        mag_r[i] <= cr[MW-1] ? MW'(-cr) : cr;
      end
      mag2_r <= mag_r;
      neg2_r <= neg_r;
      k_r    <= k_nxt;
      for (int i = 0; i < 3; i++) begin
        v_r[i] <= VW'(mag2_r[i] >> k_r);
      end
      neg3_r <= neg2_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= v_r[i] * v_r[i];
      end
      neg4_r <= neg3_r;
      work_r.s     <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      work_r.degen <= (sq_r[0] == '0) && (sq_r[1] == '0) && (sq_r[2] == '0);
      for (int i = 0; i < 3; i++) begin
        work_r.t[i] <= {sq_r[i], {(2*NORM_FRAC){1'b0}}};
        work_r.p[i] <= '0;
        work_r.q[i] <= '0;
        work_r.m[i] <= '0;
      end
      work_r.neg <= neg4_r;
    end
  end

  assign out_vld = vld_r[NS-1];
  assign work    = work_r;

endmodule

// ----- hdl/tun_cell.sv -----
// ----------------------------------------------------------------------------
// tun_cell: one quotient bit of the normalization
// Tests m|bit against m*m*S <= v*v*2^60, tracking m*m*S and m*S by adds.
// ----------------------------------------------------------------------------
module tun_cell import tun_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  tun_work_t in_work,
  output logic      out_vld,
  output tun_work_t out_work
);

  logic      vld_r;
  tun_work_t work_r, work_nxt;

  always_comb begin
    work_nxt = in_work;
    for (int i = 0; i < 3; i++) begin
      logic [PW-1:0] cand;
      cand = in_work.p[i] + (PW'(in_work.q[i]) << (BIT + 1))
           + (PW'(in_work.s) << (2 * BIT));
      if (cand <= PW'(in_work.t[i])) begin
        work_nxt.p[i]      = cand;
        work_nxt.q[i]      = in_work.q[i] + (QW'(in_work.s) << BIT);
        work_nxt.m[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_work = work_r;

endmodule

// ----- tb/tb_triangle_unit_normal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal: self-checking bench for the triangle normal unit
// Streams triangles through the block under random source and sink gaps and
// compares each normal and degenerate flag with a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal;
  import tun_pkg::*;

  localparam int CW      = 32;
  localparam int DW      = ((9*CW+7)/8)*8;
  localparam int N_RAND  = 1950;
  localparam int LIMIT   = 400000;
  localparam int LATENCY = 39;

  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic        degen;
  } normal_t;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_tvalid = 0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 0;
  logic [95:0]   out_tdata;
  logic          out_tuser;

  triangle_unit_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  logic [DW-1:0] tri_q[$];
  normal_t       normal_q[$];
  int            n_err = 0, n_out = 0, n_degen = 0, cycles = 0;
  bit            stim_done = 0;
  bit            hold_sink = 0;
  bit            hold_src = 0;

  function automatic logic signed [31:0] sat_sub(logic signed [31:0] p,
                                                 logic signed [31:0] q);
    logic signed [32:0] d;
    d = 33'(p) - 33'(q);
    if (d > 33'sd2147483647) return 32'sh7fffffff;
    if (d < -33'sd2147483648) return 32'sh80000000;
    return d[31:0];
  endfunction

  function automatic normal_t face_normal(logic [DW-1:0] d);
    logic signed [31:0]  ab[3], bc[3];
    logic signed [65:0]  cr[3];
    logic [65:0]         mag[3];
    logic [65:0]         any;
    logic [63:0]         v[3];
    logic [63:0]         s;
    logic [127:0]        t, pr;
    logic [63:0]         m, cand;
    logic [31:0]         res[3];
    int                  len, k;
    normal_t             r;
    for (int i = 0; i < 3; i++) begin
      ab[i] = sat_sub(d[32*(3+i) +: 32], d[32*i +: 32]);
      bc[i] = sat_sub(d[32*(6+i) +: 32], d[32*(3+i) +: 32]);
    end
    cr[0] = 66'(ab[1]) * 66'(bc[2]) - 66'(ab[2]) * 66'(bc[1]);
    cr[1] = 66'(ab[2]) * 66'(bc[0]) - 66'(ab[0]) * 66'(bc[2]);
    cr[2] = 66'(ab[0]) * 66'(bc[1]) - 66'(ab[1]) * 66'(bc[0]);
    any = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 66'(-cr[i]) : 66'(cr[i]);
      any |= mag[i];
    end
    r = '0;
    if (any == 0) begin
      r.degen = 1;
      return r;
    end
    len = 0;
    for (int b = 0; b < 66; b++) if (any[b]) len = b + 1;
    k = len > 31 ? len - 31 : 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = 64'(mag[i] >> k);
      s += v[i] * v[i];
    end
    for (int i = 0; i < 3; i++) begin
      t = 128'(v[i] * v[i]) << 60;
      m = 0;
      for (int b = 30; b >= 0; b--) begin
        cand = m | (64'd1 << b);
        pr = 128'(cand * cand) * 128'(s);
        if (pr <= t) m = cand;
      end
      res[i] = cr[i] < 0 ? 32'(-m) : 32'(m);
    end
    r.nx = res[0];
    r.ny = res[1];
    r.nz = res[2];
    return r;
  endfunction

  function automatic logic [DW-1:0] pack_tri(logic [31:0] c[9]);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = c[i];
    return d;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  task automatic add_tri(logic [31:0] c[9]);
    tri_q.push_back(pack_tri(c));
  endtask

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        normal_q.push_back(face_normal(in_tdata));
        src_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (src_gap > 0 || hold_src || tri_q.size() == 0) begin
          if (src_gap > 0) src_gap--;
          in_tvalid <= 0;
        end else begin
          in_tvalid <= 1;
          in_tdata  <= tri_q.pop_front();
        end
      end
    end
  end

  // monitor
  int sink_gap = 0;
  always @(posedge clk) begin
    normal_t got, exp;
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tuser};
        n_out++;
        if (out_tuser) n_degen++;
        if (normal_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected transfer %h", got);
        end else begin
          exp = normal_q.pop_front();
          if (got !== exp) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch #%0d: exp x=%h y=%h z=%h dg=%b got x=%h y=%h z=%h dg=%b",
                       n_out, exp.nx, exp.ny, exp.nz, exp.degen,
                       got.nx, got.ny, got.nz, got.degen);
          end
        end
        sink_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      end
      if (hold_sink || sink_gap > 0) begin
        if (sink_gap > 0 && !hold_sink) sink_gap--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // long sink stall
  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_sink = 1;
    repeat (150) @(posedge clk);
    hold_sink = 0;
  end

  initial begin
    logic [31:0] c[9];
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // directed: degenerate, unit axes, extremes, saturating edges
    c = '{default: 0};                                add_tri(c);
    c = '{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0}; add_tri(c);
    c = '{0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000}; add_tri(c);
    c = '{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 32'h10000}; add_tri(c);
    c = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000};
    add_tri(c);
    c = '{default: 32'h7fffffff};                      add_tri(c);
    c = '{default: 32'h80000000};                      add_tri(c);
    c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff}; add_tri(c);
    c = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000}; add_tri(c);
    c = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 32'hffffffff, 32'hffffffff,
          0, 0, 32'hffffffff}; add_tri(c);
    c = '{0, 0, 0, 1, 0, 0, 1, 1, 0};                  add_tri(c);
    c = '{0, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 1, 0}; add_tri(c);
    c = '{32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 32'h7fffffff, 0};
    add_tri(c);
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 9; j++) c[j] = $urandom();
      add_tri(c);
    end
    wait (tri_q.size() == 0 && normal_q.size() == 0);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 1000) begin
        hold_src = 1;
        wait (!in_tvalid && normal_q.size() == 0);
        hold_src = 0;
      end
      for (int j = 0; j < 9; j++) c[j] = rand_coord();
      case ($urandom_range(0, 9))
        0: for (int j = 0; j < 3; j++) c[6+j] = c[3+j];
        1: for (int j = 0; j < 3; j++) c[6+j] = 2*c[3+j] - c[j];
        default: ;
      endcase
      add_tri(c);
      if (tri_q.size() > 8) wait (tri_q.size() <= 8);
    end
    wait (tri_q.size() == 0 && !in_tvalid && normal_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d normals checked, %0d degenerate, %0d errors", n_out, n_degen, n_err);
    if (n_err == 0 && normal_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
